FILE: rtl/core/psbo_pkg.sv
// ----------------------------------------------------------------------------
// psbo_pkg
// Shared types, codes and helpers for the palette scanout block.
// ----------------------------------------------------------------------------
package psbo_pkg;

  localparam int IDX_W   = 5;
  localparam int ARGB_W  = 32;
  localparam int RGB12_W = 12;
  localparam int CFG_W   = 9;

  // item kind carried on in_tuser
  localparam logic OP_PIXEL = 1'b0;
  localparam logic OP_WRITE = 1'b1;

  // configuration register indexes
  localparam logic CFG_BEAM_FIRST = 1'b0;
  localparam logic CFG_BEAM_COUNT = 1'b1;

  localparam logic [ARGB_W-1:0] WHITE_ARGB   = 32'hFFFF_FFFF;
  localparam logic [7:0]        ALPHA_OPAQUE = 8'hFF;

  typedef struct packed {
    logic               en;
    logic [IDX_W-1:0]   slot;
    logic [ARGB_W-1:0]  color;
  } pal_wr_t;

  // 0RGB 4:4:4 to ARGB 8:8:8:8 by nibble repeat
  function automatic logic [ARGB_W-1:0] expand_color(input logic [RGB12_W-1:0] rgb);
    expand_color = {ALPHA_OPAQUE, rgb[11:8], rgb[11:8], rgb[7:4], rgb[7:4],
                    rgb[3:0], rgb[3:0]};
  endfunction

endpackage

FILE: rtl/core/psbo_palette.sv
// ----------------------------------------------------------------------------
// psbo_palette
// Color table with per-entry valid bits; unwritten and out-of-range entries
// read as zero.
// ----------------------------------------------------------------------------
module psbo_palette #(
  parameter int TABLE_ENTRIES = 32
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  psbo_pkg::pal_wr_t            wr,
  input  logic [psbo_pkg::IDX_W-1:0]   rd_idx,
  output logic [psbo_pkg::ARGB_W-1:0]  rd_color
);
  import psbo_pkg::*;

  // a five-bit index never reaches past 32 entries
  localparam int DEPTH = (TABLE_ENTRIES < 32) ? TABLE_ENTRIES : 32;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [ARGB_W-1:0] mem_r [DEPTH];
  logic [DEPTH-1:0]  vld_r;
  logic              wr_ok;
  logic              rd_ok;

  assign wr_ok = wr.en && (int'(wr.slot) < TABLE_ENTRIES);
  assign rd_ok = (int'(rd_idx) < TABLE_ENTRIES);

  always_ff @(posedge clk) begin
    if (wr_ok) begin
      mem_r[wr.slot[AW-1:0]] <= wr.color;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (wr_ok) begin
      vld_r[wr.slot[AW-1:0]] <= 1'b1;
    end
  end

  always_comb begin
    rd_color = '0;
    if (rd_ok && vld_r[rd_idx[AW-1:0]]) begin
      rd_color = mem_r[rd_idx[AW-1:0]];
    end
  end

endmodule

FILE: rtl/core/palette_scanout_with_beam_override.sv
// ----------------------------------------------------------------------------
// palette_scanout_with_beam_override
// Indexed pixel to ARGB8888 lookup with a white beam band override.
// ----------------------------------------------------------------------------
// Takes one word per clock: a palette write (tuser high) stores a 12-bit 0RGB
// color widened to ARGB with alpha FF, a pixel (tuser low) looks up its low
// five index bits and produces one output word. Rows inside the configured
// beam band turn every non-zero index into opaque white. Throughput is one
// word per cycle while the output side is ready; a pixel is held in the input
// register and in_tready drops in the same cycle when the output word is not
// taken. A pixel passes from the input register through the palette lookup
// and band compare into the output register before it appears on the output.
// out_tlast marks the last pixel of a frame. The palette reads as zero after
// reset without any clearing pass.
module palette_scanout_with_beam_override #(
  parameter int LINE_PIXELS   = 320,
  parameter int FRAME_LINES   = 256,
  parameter int TABLE_ENTRIES = 32
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_tvalid,
  output logic                          in_tready,
  // [7:0] pixel_index, [12:8] palette_slot, [24:13] source_color, [31:25] zero
  input  logic [31:0]                   in_tdata,
  // [0] operation
  input  logic                          in_tuser,
  output logic                          out_tvalid,
  input  logic                          out_tready,
  // [31:0] argb_pixel
  output logic [psbo_pkg::ARGB_W-1:0]   out_tdata,
  output logic                          out_tlast,
  input  logic                          cfg_we,
  input  logic                          cfg_index,
  input  logic [psbo_pkg::CFG_W-1:0]    cfg_wdata
);
  import psbo_pkg::*;

  localparam logic [8:0] COL_LAST = 9'(LINE_PIXELS - 1);
  localparam logic [7:0] ROW_LAST = 8'(FRAME_LINES - 1);

  // input register
  logic               s0_valid_r;
  logic               s0_op_r;
  logic [7:0]         s0_pix_r;
  logic [IDX_W-1:0]   s0_slot_r;
  logic [RGB12_W-1:0] s0_rgb_r;

  // output register
  logic               out_valid_r;
  logic [ARGB_W-1:0]  out_data_r;
  logic               out_last_r;

  logic [8:0]         col_r, col_nxt;
  logic [7:0]         row_r, row_nxt;
  logic [CFG_W-1:0]   beam_first_r;
  logic [CFG_W-1:0]   beam_count_r;

  logic               out_free;
  logic               s0_adv;
  logic               pix_go;
  logic               in_acc;
  pal_wr_t            pal_wr;
  logic [ARGB_W-1:0]  pal_color;
  logic [IDX_W-1:0]   idx;
  logic [9:0]         band_end;
  logic               in_band;
  logic               col_wrap;
  logic               row_wrap;
  logic [ARGB_W-1:0]  pix_color;

  assign out_free  = !out_valid_r || out_tready;
  // writes leave no result, so they never wait on the output side
  assign s0_adv    = s0_valid_r && ((s0_op_r == OP_WRITE) || out_free);
  assign pix_go    = s0_valid_r && (s0_op_r == OP_PIXEL) && out_free;
  assign in_tready = !s0_valid_r || s0_adv;
  assign in_acc    = in_tvalid && in_tready;

  assign pal_wr.en    = s0_valid_r && (s0_op_r == OP_WRITE);
  assign pal_wr.slot  = s0_slot_r;
  assign pal_wr.color = expand_color(s0_rgb_r);

  assign idx = s0_pix_r[IDX_W-1:0];

  psbo_palette #(
    .TABLE_ENTRIES (TABLE_ENTRIES)
  ) u_palette (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr       (pal_wr),
    .rd_idx   (idx),
    .rd_color (pal_color)
  );

  // band is first <= row < first + count, disabled when first is negative
  assign band_end = {1'b0, beam_first_r} + {1'b0, beam_count_r};
  assign in_band  = !beam_first_r[8] && (row_r >= beam_first_r[7:0]) &&
                    ({2'b00, row_r} < band_end);

  assign pix_color = (in_band && (idx != '0)) ? WHITE_ARGB : pal_color;

  assign col_wrap = (col_r >= COL_LAST);
  assign row_wrap = (row_r >= ROW_LAST);

  always_comb begin
    col_nxt = col_r + 9'd1;
    row_nxt = row_r;
    if (col_wrap) begin
      col_nxt = '0;
      row_nxt = row_wrap ? 8'd0 : row_r + 8'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_valid_r   <= 1'b0;
      out_valid_r  <= 1'b0;
      col_r        <= '0;
      row_r        <= '0;
      beam_first_r <= '1;
      beam_count_r <= 9'd1;
    end else begin
      if (in_tready) begin
        s0_valid_r <= in_tvalid;
      end
      if (pix_go) begin
        out_valid_r <= 1'b1;
        col_r       <= col_nxt;
        row_r       <= row_nxt;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
      if (cfg_we) begin
        case (cfg_index)
          CFG_BEAM_FIRST: beam_first_r <= cfg_wdata;
          CFG_BEAM_COUNT: beam_count_r <= cfg_wdata;
          default:        ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s0_op_r   <= in_tuser;
      s0_pix_r  <= in_tdata[7:0];
      s0_slot_r <= in_tdata[12:8];
      s0_rgb_r  <= in_tdata[24:13];
    end
    if (pix_go) begin
      out_data_r <= pix_color;
      out_last_r <= col_wrap && row_wrap;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tlast  = out_last_r;

endmodule

FILE: dv/palette_scanout_with_beam_override_tb.sv
// ----------------------------------------------------------------------------
// palette_scanout_with_beam_override_tb
// Self-checking bench for the palette lookup with white beam band.
// Palette writes and indexed pixels stream in with random gaps and output
// stalls. A scoreboard keeps its own palette, raster counters and band setup,
// and checks every output word in order. One phase holds the output off for a
// long stretch so the block fills up and stalls its input.
// ----------------------------------------------------------------------------
module palette_scanout_with_beam_override_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import psbo_pkg::*;

  localparam int LINE_PIXELS   = 320;
  localparam int FRAME_LINES   = 256;
  localparam int TABLE_ENTRIES = 32;
  localparam int DRAIN_CYCLES  = 4;
  localparam int HOLD_CYCLES   = 300;

  class palette_scoreboard;
    typedef struct {
      logic [ARGB_W-1:0] argb;
      logic              last;
    } scan_pixel_t;

    logic [ARGB_W-1:0] palette [TABLE_ENTRIES];
    int unsigned       col;
    int unsigned       row;
    int                band_first;
    int                band_len;
    scan_pixel_t       due [$];
    int                errors;

    function void clear();
      foreach (palette[i]) palette[i] = '0;
      col         = 0;
      row         = 0;
      band_first  = -1;
      band_len    = 1;
      errors      = 0;
      due.delete();
    endfunction

    function void write_reg(logic idx, logic [CFG_W-1:0] value);
      if (idx == CFG_BEAM_FIRST) begin
        band_first = $signed(value);
      end else begin
        band_len = value;
      end
    endfunction

    function void note_input(logic op, logic [7:0] pix, logic [4:0] slot,
                             logic [RGB12_W-1:0] rgb);
      scan_pixel_t     p;
      logic [IDX_W-1:0] idx;
      bit              in_band;
      if (op == OP_WRITE) begin
        if (slot < TABLE_ENTRIES) begin
          palette[slot] = {8'hFF, {2{rgb[11:8]}}, {2{rgb[7:4]}}, {2{rgb[3:0]}}};
        end
        return;
      end
      idx = pix[IDX_W-1:0];
      // band end is formed without wrap, so it may run past the last row
      in_band = (band_first >= 0) && (int'(row) >= band_first) &&
                (int'(row) < band_first + band_len);
      if (in_band && idx != 0) begin
        p.argb = WHITE_ARGB;
      end else if (idx < TABLE_ENTRIES) begin
        p.argb = palette[idx];
      end else begin
        p.argb = '0;
      end
      p.last = (col == LINE_PIXELS - 1) && (row == FRAME_LINES - 1);
      due.push_back(p);
      if (col >= LINE_PIXELS - 1) begin
        col = 0;
        if (row >= FRAME_LINES - 1) begin
          row = 0;
        end else begin
          row++;
        end
      end else begin
        col++;
      end
    endfunction

    function void check_output(logic [ARGB_W-1:0] argb, logic last);
      scan_pixel_t p;
      if (due.size() == 0) begin
        errors++;
        $display("%0t: unexpected word, expected none, got argb %08h last %0b",
                 $time, argb, last);
        return;
      end
      p = due.pop_front();
      if (argb !== p.argb) begin
        errors++;
        $display("%0t: argb mismatch, expected %08h, got %08h", $time, p.argb, argb);
      end
      if (last !== p.last) begin
        errors++;
        $display("%0t: frame end mismatch, expected %0b, got %0b", $time, p.last, last);
      end
    endfunction

    function int pending();
      return due.size();
    endfunction
  endclass

  logic               clk        = 1'b0;
  logic               rst_n      = 1'b0;
  logic               in_tvalid  = 1'b0;
  logic               in_tready;
  logic [31:0]        in_tdata   = '0;
  logic               in_tuser   = OP_PIXEL;
  logic               out_tvalid;
  logic               out_tready = 1'b0;
  logic [ARGB_W-1:0]  out_tdata;
  logic               out_tlast;
  logic               cfg_we     = 1'b0;
  logic               cfg_index  = CFG_BEAM_FIRST;
  logic [CFG_W-1:0]   cfg_wdata  = '0;

  palette_scoreboard sb = new;
  bit tx_idle    = 1'b1;
  bit rx_idle    = 1'b1;
  int hold_asks  = 0;
  int holds_done = 0;
  int hold_left  = 0;

  palette_scanout_with_beam_override #(
    .LINE_PIXELS  (LINE_PIXELS),
    .FRAME_LINES  (FRAME_LINES),
    .TABLE_ENTRIES(TABLE_ENTRIES)
  ) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tlast (out_tlast),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  // output side: random stalls, plus a long hold-off whenever one is asked for
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else if (hold_left != 0) begin
      out_tready <= 1'b0;
      hold_left  <= hold_left - 1;
    end else if (holds_done != hold_asks) begin
      out_tready <= 1'b0;
      holds_done <= holds_done + 1;
      hold_left  <= HOLD_CYCLES;
    end else begin
      out_tready <= rx_idle ? ($urandom_range(0, 99) >= 10) : 1'b1;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      sb.check_output(out_tdata, out_tlast);
    end
  end

  // expects to be entered right after a rising edge, returns at the accepting edge
  task automatic send_word(input logic op, input logic [7:0] pix, input logic [4:0] slot,
                           input logic [RGB12_W-1:0] rgb);
    int gap;
    gap = 0;
    if (tx_idle && $urandom_range(0, 99) < 10) gap = $urandom_range(1, 4);
    if (gap != 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tdata  <= {7'd0, rgb, slot, pix};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    sb.note_input(op, pix, slot, rgb);
  endtask

  task automatic send_pixel(input logic [7:0] pix);
    send_word(OP_PIXEL, pix, 5'($urandom), 12'($urandom));
  endtask

  task automatic send_write(input logic [4:0] slot, input logic [RGB12_W-1:0] rgb);
    send_word(OP_WRITE, 8'($urandom), slot, rgb);
  endtask

  task automatic random_phase(input int n, input int write_pct);
    logic [7:0] pix;
    for (int i = 0; i < n; i++) begin
      pix = 8'($urandom);
      // zero index is the one that escapes the band, so give it more weight
      if ($urandom_range(0, 99) < 15) pix[4:0] = '0;
      if ($urandom_range(0, 99) < write_pct) begin
        send_word(OP_WRITE, pix, 5'($urandom), 12'($urandom));
      end else begin
        send_word(OP_PIXEL, pix, 5'($urandom), 12'($urandom));
      end
    end
  endtask

  task automatic drain();
    in_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    // a trailing palette write may still be in flight
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic idx, input logic [CFG_W-1:0] value);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    @(posedge clk);
    sb.write_reg(idx, value);
  endtask

  task automatic set_band(input logic [CFG_W-1:0] first, input logic [CFG_W-1:0] count);
    drain();
    write_reg(CFG_BEAM_FIRST, first);
    write_reg(CFG_BEAM_COUNT, count);
    cfg_we <= 1'b0;
  endtask

  // band start picked around the current row so the band edges get crossed
  function automatic logic [CFG_W-1:0] pick_first();
    int unsigned r;
    r = sb.row;
    case ($urandom_range(0, 4))
      0:       return 9'h1FF;
      1:       return 9'(r);
      2:       return 9'((r < 255) ? r + 1 : r);
      3:       return 9'((r > 0) ? r - 1 : 0);
      default: return 9'($urandom_range(0, 255));
    endcase
  endfunction

  function automatic logic [CFG_W-1:0] pick_count();
    case ($urandom_range(0, 4))
      0:       return 9'd0;
      1:       return 9'd1;
      2:       return 9'd256;
      3:       return 9'($urandom_range(1, 3));
      default: return 9'($urandom_range(0, 256));
    endcase
  endfunction

  initial begin
    int  k;
    bit  quiet;
    sb.clear();
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // palette is zero after reset, band disabled
    send_pixel(8'h00);
    send_pixel(8'hFF);
    send_write(5'd0, 12'h000);
    send_write(5'd31, 12'hFFF);
    send_write(5'd5, 12'h5A3);
    send_write(5'd17, 12'hC0E);
    send_pixel(8'hE0);
    send_pixel(8'h1F);
    send_pixel(8'hA5);
    send_pixel(8'h71);
    send_write(5'd5, 12'h0F0);
    send_pixel(8'h05);

    // band on row 0: non-zero indexes go white, zero index still looks up
    set_band(9'd0, 9'd1);
    send_pixel(8'h00);
    send_pixel(8'hE0);
    send_pixel(8'h01);
    send_pixel(8'hFF);
    set_band(9'd0, 9'd0);
    send_pixel(8'h1F);
    set_band(9'd0, 9'd256);
    send_pixel(8'h11);
    send_write(5'd1, 12'h321);
    send_pixel(8'h01);
    set_band(9'd255, 9'd256);
    send_pixel(8'h01);
    set_band(9'h1FF, 9'd256);
    send_pixel(8'hFE);

    for (k = 0; k < 20; k++) begin
      set_band(pick_first(), pick_count());
      quiet   = (k == 6);
      tx_idle = !quiet;
      rx_idle <= !quiet;
      if (k == 12) begin
        // sender keeps pushing while the output is held off
        tx_idle = 1'b0;
        hold_asks <= hold_asks + 1;
        random_phase(400, 20);
      end else if (quiet) begin
        random_phase(150, 20);
      end else begin
        random_phase(40, 20);
      end
    end

    tx_idle = 1'b1;
    rx_idle <= 1'b1;
    set_band(pick_first(), pick_count());
    random_phase(300, 20);

    drain();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("** palette_scanout_with_beam_override: PASSED **");
    end else begin
      $display("** palette_scanout_with_beam_override: FAILED **");
    end
    $finish;
  end

  initial begin
    #40_000_000;
    $display("%0t: timeout", $time);
    $display("** palette_scanout_with_beam_override: FAILED **");
    $finish;
  end

endmodule
